FILE: rtl/xs20_pkg.sv
// shared types, constants and salsa20 round functions for the xsalsa20 stream core
`default_nettype none
package xs20_pkg;

   localparam int NumRegs   = 7;
   localparam int NumRounds = 20;

   // register indexes
   localparam logic [2:0] RegKey0   = 3'd0;
   localparam logic [2:0] RegKey1   = 3'd1;
   localparam logic [2:0] RegKey2   = 3'd2;
   localparam logic [2:0] RegKey3   = 3'd3;
   localparam logic [2:0] RegNonce0 = 3'd4;
   localparam logic [2:0] RegNonce1 = 3'd5;
   localparam logic [2:0] RegNonce2 = 3'd6;

   localparam logic [31:0] Sigma0 = 32'h6170_7865;
   localparam logic [31:0] Sigma1 = 32'h3320_646E;
   localparam logic [31:0] Sigma2 = 32'h7962_2D32;
   localparam logic [31:0] Sigma3 = 32'h6B20_6574;

   typedef struct packed {
      logic [63:0] message_word;
      logic [3:0]  valid_bytes;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [63:0] cipher_word;
      logic [3:0]  out_valid_bytes;
      logic        out_last;
   } rsp_type;

   typedef logic [15:0][31:0] mat_type;
   typedef logic [7:0][31:0]  key_type;
   typedef logic [3:0][31:0]  nw_type;

   // controller to datapath
   typedef struct packed {
      logic       in_load;
      logic       load_sub;
      logic       load_blk;
      logic       round_en;
      logic       row_round;
      logic       save_sub;
      logic       save_ks;
      logic       ctr_clr;
      logic       ctr_inc;
      logic       out_load;
      logic [2:0] ks_sel;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_last;
   } sts_type;

   function automatic logic [31:0] rotl(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   // quarter round, returns {d, c, b, a}
   function automatic nw_type qround(logic [31:0] a, logic [31:0] b,
                                     logic [31:0] c, logic [31:0] d);
      logic [31:0] a1, b1, c1, d1;
      nw_type      r;
      b1 = b ^ rotl(a + d, 7);
      c1 = c ^ rotl(b1 + a, 9);
      d1 = d ^ rotl(c1 + b1, 13);
      a1 = a ^ rotl(d1 + c1, 18);
      r[0] = a1;
      r[1] = b1;
      r[2] = c1;
      r[3] = d1;
      return r;
   endfunction

   // one column round or one row round
   function automatic mat_type salsa_round(mat_type x, logic row);
      mat_type y;
      nw_type  q0, q1, q2, q3;
      if (row) begin
         q0 = qround(x[0], x[1], x[2], x[3]);
         q1 = qround(x[5], x[6], x[7], x[4]);
         q2 = qround(x[10], x[11], x[8], x[9]);
         q3 = qround(x[15], x[12], x[13], x[14]);
         y[0] = q0[0];  y[1] = q0[1];  y[2] = q0[2];  y[3] = q0[3];
         y[5] = q1[0];  y[6] = q1[1];  y[7] = q1[2];  y[4] = q1[3];
         y[10] = q2[0]; y[11] = q2[1]; y[8] = q2[2];  y[9] = q2[3];
         y[15] = q3[0]; y[12] = q3[1]; y[13] = q3[2]; y[14] = q3[3];
      end else begin
         q0 = qround(x[0], x[4], x[8], x[12]);
         q1 = qround(x[5], x[9], x[13], x[1]);
         q2 = qround(x[10], x[14], x[2], x[6]);
         q3 = qround(x[15], x[3], x[7], x[11]);
         y[0] = q0[0];  y[4] = q0[1];  y[8] = q0[2];  y[12] = q0[3];
         y[5] = q1[0];  y[9] = q1[1];  y[13] = q1[2]; y[1] = q1[3];
         y[10] = q2[0]; y[14] = q2[1]; y[2] = q2[2];  y[6] = q2[3];
         y[15] = q3[0]; y[3] = q3[1];  y[7] = q3[2];  y[11] = q3[3];
      end
      return y;
   endfunction

   function automatic mat_type build_matrix(key_type k, nw_type n);
      mat_type m;
      m[0]  = Sigma0;
      m[1]  = k[0];
      m[2]  = k[1];
      m[3]  = k[2];
      m[4]  = k[3];
      m[5]  = Sigma1;
      m[6]  = n[0];
      m[7]  = n[1];
      m[8]  = n[2];
      m[9]  = n[3];
      m[10] = Sigma2;
      m[11] = k[4];
      m[12] = k[5];
      m[13] = k[6];
      m[14] = k[7];
      m[15] = Sigma3;
      return m;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/xsalsa20_stream_xor_core.sv
// top level of the xsalsa20 stream encrypt/decrypt core
`default_nettype none
// xsalsa20 stream xor core. load the 256-bit key (csr 0..3) and the 192-bit
// nonce (csr 4..6) as little-endian bytes while the core is idle, then send
// 64-bit message beats on req; each returns one beat on rsp holding the
// message xor keystream, with bytes past valid_bytes forced to zero. the first
// beat of a message derives the hsalsa20 subkey, and every eighth beat builds a
// new 64-byte salsa20 block; last_word closes the message and rewinds the
// block counter. one shared round unit does one column or row round per
// cycle. a beat inside a block passes through idle and output steps; a
// block boundary adds a block load, 20 rounds and the feed-forward, and
// the first beat of a message adds 20 hsalsa20 subkey rounds and the
// subkey save. a held output register lets the next beat be taken while a
// result waits on rsp.
module xsalsa20_stream_xor_core (
   input  wire logic            clock,
   input  wire logic            reset,
   // config write port
   input  wire logic            csr_we,
   input  wire logic [2:0]      csr_index,
   input  wire logic [63:0]     csr_wdata,
   // input beats
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire xs20_pkg::req_type req_data,
   // result beats
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output xs20_pkg::rsp_type    rsp_data
);

   xs20_pkg::cmd_type cmd;
   xs20_pkg::sts_type sts;

   // sequencing: beat buffering, round counting, word position
   xs20_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // round state, subkey, keystream block and beat registers
   xs20_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: rtl/xs20_datapath.sv
// xsalsa20 datapath: key registers, round state, subkey, keystream and beat registers
`default_nettype none
module xs20_datapath (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_we,
   input  wire logic [2:0]      csr_index,
   input  wire logic [63:0]     csr_wdata,
   input  wire xs20_pkg::req_type req_data,
   input  wire xs20_pkg::cmd_type cmd,
   output xs20_pkg::sts_type    sts,
   output xs20_pkg::rsp_type    rsp_data
);

   logic [63:0]           cfg_ff [xs20_pkg::NumRegs];
   logic [63:0]           ctr_ff;
   xs20_pkg::mat_type     x_ff;
   xs20_pkg::key_type     subkey_ff;
   logic [7:0][63:0]      ks_ff;
   xs20_pkg::req_type     req_ff;
   xs20_pkg::rsp_type     rsp_ff;

   xs20_pkg::mat_type     hs_init;
   xs20_pkg::mat_type     blk_init;
   xs20_pkg::mat_type     x_in;
   logic [63:0]           ks_word;
   logic [63:0]           masked;

   assign hs_init = xs20_pkg::build_matrix(
      {cfg_ff[xs20_pkg::RegKey3], cfg_ff[xs20_pkg::RegKey2],
       cfg_ff[xs20_pkg::RegKey1], cfg_ff[xs20_pkg::RegKey0]},
      {cfg_ff[xs20_pkg::RegNonce1], cfg_ff[xs20_pkg::RegNonce0]});

   assign blk_init = xs20_pkg::build_matrix(subkey_ff,
      {ctr_ff, cfg_ff[xs20_pkg::RegNonce2]});

   always_comb begin
      x_in = x_ff;
      if (cmd.load_sub) begin
         x_in = hs_init;
      end else if (cmd.load_blk) begin
         x_in = blk_init;
      end else if (cmd.round_en) begin
         x_in = xs20_pkg::salsa_round(x_ff, cmd.row_round);
      end
   end

   assign ks_word = ks_ff[cmd.ks_sel];

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         masked[8*i +: 8] = (req_ff.valid_bytes > 4'(i)) ?
                            (req_ff.message_word[8*i +: 8] ^ ks_word[8*i +: 8]) : 8'h00;
      end
   end

   // control-like state: config and block counter
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < xs20_pkg::NumRegs; i++) begin
            cfg_ff[i] <= '0;
         end
         ctr_ff <= '0;
      end else begin
         if (csr_we && (csr_index < 3'(xs20_pkg::NumRegs))) begin
            cfg_ff[csr_index] <= csr_wdata;
         end
         if (cmd.ctr_clr) begin
            ctr_ff <= '0;
         end else if (cmd.ctr_inc) begin
            ctr_ff <= ctr_ff + 64'd1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (cmd.save_sub) begin
         subkey_ff <= {x_ff[9], x_ff[8], x_ff[7], x_ff[6],
                       x_ff[15], x_ff[10], x_ff[5], x_ff[0]};
      end
      if (cmd.save_ks) begin
         for (int i = 0; i < 8; i++) begin
            ks_ff[i] <= {x_ff[2*i+1] + blk_init[2*i+1], x_ff[2*i] + blk_init[2*i]};
         end
      end
      if (cmd.in_load) begin
         req_ff <= req_data;
      end
      if (cmd.out_load) begin
         rsp_ff.cipher_word     <= masked;
         rsp_ff.out_valid_bytes <= req_ff.valid_bytes;
         rsp_ff.out_last        <= req_ff.last_word;
      end
   end

   assign sts.in_last = req_ff.last_word;
   assign rsp_data    = rsp_ff;

endmodule
`default_nettype wire

FILE: rtl/xs20_ctrl.sv
// xsalsa20 controller: sequencing of subkey, keystream blocks and beats
`default_nettype none
module xs20_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire xs20_pkg::sts_type sts,
   output xs20_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUB,
      S_SKEY,
      S_LOADB,
      S_BLK,
      S_KS,
      S_EMIT
   } state_type;

   localparam logic [4:0] LastRound = 5'(xs20_pkg::NumRounds - 1);

   state_type  state_ff, state_in;
   logic [4:0] rnd_ff, rnd_in;
   logic [2:0] pos_ff, pos_in;
   logic       active_ff, active_in;
   logic       in_full_ff, in_full_in;
   logic       out_full_ff, out_full_in;
   logic       req_accept;

   assign req_ready  = !in_full_ff;
   assign rsp_valid  = out_full_ff;
   assign req_accept = req_valid && !in_full_ff;

   always_comb begin
      state_in  = state_ff;
      rnd_in    = rnd_ff;
      pos_in    = pos_ff;
      active_in = active_ff;
      cmd           = '0;
      cmd.in_load   = req_accept;
      cmd.row_round = rnd_ff[0];
      cmd.ks_sel    = pos_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_full_ff) begin
               if (!active_ff) begin
                  cmd.load_sub = 1'b1;
                  cmd.ctr_clr  = 1'b1;
                  pos_in       = '0;
                  active_in    = 1'b1;
                  rnd_in       = '0;
                  state_in     = S_SUB;
               end else if (pos_ff == 3'd0) begin
                  state_in = S_LOADB;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_SUB: begin
            cmd.round_en = 1'b1;
            rnd_in       = rnd_ff + 5'd1;
            if (rnd_ff == LastRound) begin
               state_in = S_SKEY;
            end
         end
         S_SKEY: begin
            cmd.save_sub = 1'b1;
            state_in     = S_LOADB;
         end
         S_LOADB: begin
            cmd.load_blk = 1'b1;
            rnd_in       = '0;
            state_in     = S_BLK;
         end
         S_BLK: begin
            cmd.round_en = 1'b1;
            rnd_in       = rnd_ff + 5'd1;
            if (rnd_ff == LastRound) begin
               state_in = S_KS;
            end
         end
         S_KS: begin
            cmd.save_ks = 1'b1;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (!out_full_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               if (sts.in_last) begin
                  active_in   = 1'b0;
                  pos_in      = '0;
                  cmd.ctr_clr = 1'b1;
               end else begin
                  pos_in      = pos_ff + 3'd1;
                  cmd.ctr_inc = (pos_ff == 3'd7);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (req_accept) begin
         in_full_in = 1'b1;
      end else if (cmd.out_load) begin
         in_full_in = 1'b0;
      end else begin
         in_full_in = in_full_ff;
      end

      if (cmd.out_load) begin
         out_full_in = 1'b1;
      end else if (rsp_ready) begin
         out_full_in = 1'b0;
      end else begin
         out_full_in = out_full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rnd_ff      <= '0;
         pos_ff      <= '0;
         active_ff   <= 1'b0;
         in_full_ff  <= 1'b0;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rnd_ff      <= rnd_in;
         pos_ff      <= pos_in;
         active_ff   <= active_in;
         in_full_ff  <= in_full_in;
         out_full_ff <= out_full_in;
      end
   end

`ifndef SYNTHESIS
   // every busy state works on a held input beat
   a_busy_has_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> in_full_ff)
      else $error("controller busy without an input beat");

   // rounds never run past the round count
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.round_en |-> (rnd_ff <= LastRound))
      else $error("round counter overran");

   // a last beat ends the message
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && sts.in_last) |=> (!active_ff && pos_ff == 3'd0))
      else $error("message not closed after last beat");

   // a keystream block is only made inside a message
   a_blk_active: assert property (@(posedge clock) disable iff (reset)
      cmd.load_blk |-> (active_ff && pos_ff == 3'd0))
      else $error("keystream block started outside block boundary");
`endif

endmodule
`default_nettype wire
